// ===== src/ldf_pkg.sv =====
// ldf_pkg: shared types and constants for the length-prefixed deframer.
// No dependencies; every other file in src refers to it by scoped names.
package ldf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_TO_DEVICE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_TO_APP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH       = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] MARKER_TO_DEVICE_RST = 8'h01;
  localparam logic [BYTE_W-1:0] MARKER_TO_APP_RST    = 8'h02;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST       = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEN_LO  = 2'd1,
    PH_LEN_HI  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] marker_to_device;
    logic [BYTE_W-1:0] marker_to_app;
    logic [LEN_W-1:0]  max_length;
  } ldf_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic              frame_empty;
  } ldf_result_t;

endpackage

// ===== src/ldf_rx_if.sv =====
// ldf_rx_if: input channel of the deframer, one received byte per item.
// Depends on ldf_pkg for the byte width.
interface ldf_rx_if;
  logic                      valid;
  logic                      ready;
  logic [ldf_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/ldf_res_if.sv =====
// ldf_res_if: result channel of the deframer, one payload byte and flags per item.
// Depends on ldf_pkg for the byte width.
interface ldf_res_if;
  logic                      valid;
  logic                      ready;
  logic [ldf_pkg::BYTE_W-1:0] payload_byte;
  logic                      frame_last;
  logic                      frame_empty;

  modport source (output valid, output payload_byte, output frame_last,
                  output frame_empty, input ready);
  modport sink   (input valid, input payload_byte, input frame_last,
                  input frame_empty, output ready);
endinterface

// ===== src/length_prefixed_deframer.sv =====
// length_prefixed_deframer: top level; input register, frame parser, result register.
// Depends on ldf_pkg, ldf_rx_if, ldf_res_if, ldf_parser and ldf_out_stage.
//
//   port     dir  handshake         carries
//   rx       in   valid/ready       rx_byte (8 bits)
//   res      out  valid/ready       payload_byte (8), frame_last, frame_empty
//   cfg_*    in   cfg_we, no ready  cfg_index (2), cfg_data (16)
//
// One item a cycle unless rx stalls: a byte waits in the input register while the
// parser state machine works on it, and any result is written into the result
// register as the parser steps on that byte. Each result passes the input register
// and then the result register before it can leave on res.
// rx stalls only when a byte that yields a result meets a full result
// register whose item is not being taken.
// Synchronous active-high rst clears the parser, both valid flags and the
// configuration registers to their defaults.
module length_prefixed_deframer (
  input  logic                           clk,
  input  logic                           rst,
  ldf_rx_if.sink                         rx,
  ldf_res_if.source                      res,
  input  logic                           cfg_we,
  input  logic [ldf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldf_pkg::CFG_W-1:0]      cfg_data
);

  ldf_pkg::ldf_cfg_t            cfg;
  ldf_pkg::ldf_result_t         result;

  logic                         in_valid;
  logic [ldf_pkg::BYTE_W-1:0]   in_byte;
  logic                         step;
  logic                         out_space;

  // Configuration registers; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.marker_to_device <= ldf_pkg::MARKER_TO_DEVICE_RST;
      cfg.marker_to_app    <= ldf_pkg::MARKER_TO_APP_RST;
      cfg.max_length       <= ldf_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ldf_pkg::CFG_MARKER_TO_DEVICE: cfg.marker_to_device <= cfg_data[ldf_pkg::BYTE_W-1:0];
        ldf_pkg::CFG_MARKER_TO_APP:    cfg.marker_to_app    <= cfg_data[ldf_pkg::BYTE_W-1:0];
        ldf_pkg::CFG_MAX_LENGTH:       cfg.max_length       <= cfg_data[ldf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held byte unless it yields a result with nowhere to go
  assign step     = in_valid && (!result.valid || out_space);
  assign rx.ready = !in_valid || step;

  // Input register: hold the byte until the parser advances on it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  ldf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .cfg     (cfg),
    .result  (result)
  );

  ldf_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step && result.valid),
    .result (result),
    .space  (out_space),
    .res    (res)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.frame_empty) |-> (res.frame_last && (res.payload_byte == '0)))
    else $error("empty frame result not flagged last or carries data");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready && step) |-> !result.valid)
    else $error("result register overwritten while held");

  a_stalled_byte_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step) |=> (in_valid && $stable(in_byte)))
    else $error("stalled input byte lost");

endmodule

// ===== src/ldf_parser.sv =====
// ldf_parser: frame state machine; works on one registered byte when stepped.
// Depends on ldf_pkg (phase_t, ldf_cfg_t, ldf_result_t).
module ldf_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [ldf_pkg::BYTE_W-1:0]  in_byte,
  input  ldf_pkg::ldf_cfg_t           cfg,
  output ldf_pkg::ldf_result_t        result
);

  ldf_pkg::phase_t              phase, phase_next;
  logic [ldf_pkg::BYTE_W-1:0]   length_low, length_low_next;
  logic [ldf_pkg::LEN_W-1:0]    bytes_left, bytes_left_next;

  logic                         byte_is_marker;
  logic                         low_is_marker;
  logic [ldf_pkg::LEN_W-1:0]    frame_len;

  assign byte_is_marker = (in_byte == cfg.marker_to_device) ||
                          (in_byte == cfg.marker_to_app);
  assign low_is_marker  = (length_low == cfg.marker_to_device) ||
                          (length_low == cfg.marker_to_app);
  assign frame_len      = {in_byte, length_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ldf_pkg::PH_HUNT;
      length_low <= '0;
      bytes_left <= '0;
    end else if (step) begin
      phase      <= phase_next;
      length_low <= length_low_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    length_low_next     = length_low;
    bytes_left_next     = bytes_left;
    result.valid        = 1'b0;
    result.payload_byte = '0;
    result.frame_last   = 1'b0;
    result.frame_empty  = 1'b0;
    case (phase)
      ldf_pkg::PH_HUNT: begin
        if (byte_is_marker) begin
          phase_next = ldf_pkg::PH_LEN_LO;
        end
      end
      ldf_pkg::PH_LEN_LO: begin
        length_low_next = in_byte;
        phase_next      = ldf_pkg::PH_LEN_HI;
      end
      ldf_pkg::PH_LEN_HI: begin
        if (frame_len > cfg.max_length) begin
          // false marker: resync on the length bytes
          if (low_is_marker) begin
            length_low_next = in_byte;
            phase_next      = ldf_pkg::PH_LEN_HI;
          end else if (byte_is_marker) begin
            phase_next = ldf_pkg::PH_LEN_LO;
          end else begin
            phase_next = ldf_pkg::PH_HUNT;
          end
        end else if (frame_len == '0) begin
          phase_next         = ldf_pkg::PH_HUNT;
          result.valid       = 1'b1;
          result.frame_last  = 1'b1;
          result.frame_empty = 1'b1;
        end else begin
          bytes_left_next = frame_len;
          phase_next      = ldf_pkg::PH_PAYLOAD;
        end
      end
      ldf_pkg::PH_PAYLOAD: begin
        result.valid        = 1'b1;
        result.payload_byte = in_byte;
        if (bytes_left <= ldf_pkg::LEN_W'(1)) begin
          bytes_left_next   = '0;
          phase_next        = ldf_pkg::PH_HUNT;
          result.frame_last = 1'b1;
        end else begin
          bytes_left_next = bytes_left - ldf_pkg::LEN_W'(1);
        end
      end
      default: begin
        phase_next = ldf_pkg::PH_HUNT;
      end
    endcase
  end

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == ldf_pkg::PH_PAYLOAD) |-> (bytes_left != '0))
    else $error("payload phase with no bytes left");

endmodule

// ===== src/ldf_out_stage.sv =====
// ldf_out_stage: result register between the parser and the result channel.
// Depends on ldf_pkg (ldf_result_t) and ldf_res_if.
module ldf_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ldf_pkg::ldf_result_t  result,
  output logic                  space,
  ldf_res_if.source             res
);

  logic                         valid;
  logic [ldf_pkg::BYTE_W-1:0]   payload_byte;
  logic                         frame_last;
  logic                         frame_empty;

  // room when empty or when the held item leaves this cycle
  assign space = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      payload_byte <= result.payload_byte;
      frame_last   <= result.frame_last;
      frame_empty  <= result.frame_empty;
    end
  end

  assign res.valid        = valid;
  assign res.payload_byte = payload_byte;
  assign res.frame_last   = frame_last;
  assign res.frame_empty  = frame_empty;

endmodule
